### hdl/rcea_pkg.sv
package rcea_pkg;
	localparam int unsigned VALUE_W = 32;
	localparam int unsigned COUNT_W = 11;
	localparam int unsigned INDEX_W = 10;
	localparam int unsigned LEN_W   = 11;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_QUERY = 1'b1
	} opcode_t;

	typedef struct packed {
		logic [COUNT_W-1:0] match_count;
		logic               bad_range;
	} result_t;
endpackage

### hdl/rcea_entry_mem.sv
module rcea_entry_mem #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned AW    = 10
) (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [AW-1:0]                 wr_addr,
	input  logic [rcea_pkg::VALUE_W-1:0]  wr_data,
	input  logic [AW-1:0]                 rd_addr,
	output logic [rcea_pkg::VALUE_W-1:0]  rd_data
);
	import rcea_pkg::*;

	logic [VALUE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule

### hdl/range_count_equal_then_assign_unit.sv
// A load whose block is tagged first spills the tag into the block; a query walks up to two
// partial blocks, spilling a tagged one first unless its tag already equals the value, and
// walks each untagged inner block. Each walked entry is read and then compared
// (S_WALK_RD/S_WALK_CMP or S_INNER_RD/S_INNER_CMP) on the entry memory.
// Throughput: one item at a time; busy is high until the cycle of the result strobe.
// Reset: arst_n clears control and tag valid bits and sets len_q to 1024; the receiver cannot stall.
module range_count_equal_then_assign_unit #(
	parameter int unsigned TABLE_DEPTH = 1024,
	parameter int unsigned BLOCK_SIZE  = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         opcode,
	input  logic [rcea_pkg::INDEX_W-1:0] range_low,
	input  logic [rcea_pkg::INDEX_W-1:0] range_high,
	input  logic signed [rcea_pkg::VALUE_W-1:0] value,
	output logic                         done,
	output logic [rcea_pkg::COUNT_W-1:0] match_count,
	output logic                         bad_range,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [rcea_pkg::LEN_W-1:0]   cfg_data
);
	import rcea_pkg::*;

	localparam int unsigned NUM_BLOCKS = (TABLE_DEPTH + BLOCK_SIZE - 1) / BLOCK_SIZE;
	localparam int unsigned AW  = $clog2(TABLE_DEPTH);
	localparam int unsigned BW  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int unsigned XW  = AW + 2;   // wide index, holds TABLE_DEPTH
	localparam logic [XW-1:0] DEPTH_X = XW'(TABLE_DEPTH);
	localparam logic [XW-1:0] BS_X    = XW'(BLOCK_SIZE);

	typedef enum logic [3:0] {
		S_IDLE, S_CHECK, S_PART_INIT, S_SPILL, S_WALK_RD, S_WALK_CMP,
		S_INNER, S_INNER_RD, S_INNER_CMP, S_DONE
	} state_t;

	state_t             state_q;
	logic               op_q;
	logic [XW-1:0]      lo_q, hi_q;
	logic [VALUE_W-1:0] val_q;
	logic [LEN_W-1:0]   len_q;
	logic [COUNT_W-1:0] cnt_q;
	logic               bad_q;
	// partial walk bounds and cursor
	logic [XW-1:0]      plo_q, phi_q, ptr_q;
	logic               second_q;   // walking the high partial block
	logic [BW-1:0]      blk_q;
	logic [XW-1:0]      ib_q;       // inner block cursor

	logic [VALUE_W-1:0] tag_val_q [NUM_BLOCKS];
	logic [NUM_BLOCKS-1:0] tag_vld_q;

	logic               mem_we;
	logic [AW-1:0]      mem_wa, mem_ra;
	logic [VALUE_W-1:0] mem_wd, mem_rd;

	rcea_entry_mem #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_mem (
		.clk(clk), .wr_en(mem_we), .wr_addr(mem_wa), .wr_data(mem_wd),
		.rd_addr(mem_ra), .rd_data(mem_rd)
	);

	logic [XW-1:0] len_eff;
	assign len_eff = (XW'(len_q) > DEPTH_X) ? DEPTH_X : XW'(len_q);

	function automatic logic [XW-1:0] blk_last(input logic [XW-1:0] b);
		logic [XW-1:0] e;
		e = b * BS_X + BS_X - XW'(1);
		return (e < DEPTH_X) ? e : DEPTH_X - XW'(1);
	endfunction

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);
	assign match_count = cnt_q;
	assign bad_range   = bad_q;

	logic [XW-1:0] blo, bhi;
	assign blo = lo_q / BS_X;
	assign bhi = hi_q / BS_X;
	logic [XW-1:0] pblk;
	assign pblk = plo_q / BS_X;

	// memory port steering
	always_comb begin
		mem_we = 1'b0;
		mem_wa = ptr_q[AW-1:0];
		mem_wd = val_q;
		mem_ra = ptr_q[AW-1:0];
		unique case (state_q)
			S_SPILL: begin
				mem_we = 1'b1;
				mem_wd = tag_val_q[blk_q];
			end
			S_WALK_CMP: begin
				mem_we = (mem_rd != val_q) && !(op_q == OP_LOAD);
				mem_wa = ptr_q[AW-1:0];
			end
			S_DONE: begin
				mem_we = (op_q == OP_LOAD) && !bad_q;
				mem_wa = lo_q[AW-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			tag_vld_q <= '0;
			len_q     <= LEN_W'(1024);
			done      <= 1'b0;
			cnt_q     <= '0;
			bad_q     <= 1'b0;
			second_q  <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cfg_valid) begin
						len_q <= cfg_data;
					end
					if (start) begin
						op_q     <= opcode;
						lo_q     <= XW'(range_low);
						hi_q     <= XW'(range_high);
						val_q    <= value;
						cnt_q    <= '0;
						bad_q    <= 1'b0;
						second_q <= 1'b0;
						state_q  <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (op_q == OP_LOAD) begin
						if (lo_q >= len_eff) begin
							bad_q   <= 1'b1;
							state_q <= S_DONE;
						end else begin
							plo_q   <= lo_q;
							phi_q   <= lo_q;
							state_q <= S_PART_INIT;
						end
					end else if (lo_q > hi_q || hi_q >= len_eff) begin
						bad_q   <= 1'b1;
						state_q <= S_DONE;
					end else begin
						plo_q   <= lo_q;
						phi_q   <= (blo == bhi) ? hi_q : blk_last(blo);
						state_q <= S_PART_INIT;
					end
				end
				S_PART_INIT: begin
					blk_q <= pblk[BW-1:0];
					if (op_q == OP_QUERY && tag_vld_q[pblk[BW-1:0]]
						&& tag_val_q[pblk[BW-1:0]] == val_q) begin
						// tag already equal: whole slice matches, nothing changes
						cnt_q <= cnt_q + COUNT_W'(phi_q - plo_q + XW'(1));
						state_q <= second_q ? S_DONE : S_INNER;
						ib_q    <= blo + XW'(1);
					end else if (tag_vld_q[pblk[BW-1:0]]) begin
						ptr_q   <= pblk * BS_X;
						state_q <= S_SPILL;
					end else begin
						ptr_q   <= plo_q;
						state_q <= (op_q == OP_LOAD) ? S_DONE : S_WALK_RD;
					end
				end
				S_SPILL: begin
					// write the tag into the block one entry a cycle
					if (ptr_q == blk_last(XW'(blk_q))) begin
						tag_vld_q[blk_q] <= 1'b0;
						ptr_q   <= plo_q;
						state_q <= (op_q == OP_LOAD) ? S_DONE : S_WALK_RD;
					end else begin
						ptr_q <= ptr_q + XW'(1);
					end
				end
				S_WALK_RD: begin
					state_q <= S_WALK_CMP;
				end
				S_WALK_CMP: begin
					if (mem_rd == val_q) begin
						cnt_q <= cnt_q + COUNT_W'(1);
					end
					if (ptr_q == phi_q) begin
						ib_q    <= blo + XW'(1);
						state_q <= second_q ? S_DONE : S_INNER;
					end else begin
						ptr_q   <= ptr_q + XW'(1);
						state_q <= S_WALK_RD;
					end
				end
				S_INNER: begin
					if (blo == bhi) begin
						state_q <= S_DONE;
					end else if (ib_q >= bhi) begin
						second_q <= 1'b1;
						plo_q    <= bhi * BS_X;
						phi_q    <= hi_q;
						state_q  <= S_PART_INIT;
					end else if (tag_vld_q[ib_q[BW-1:0]]) begin
						if (tag_val_q[ib_q[BW-1:0]] == val_q) begin
							cnt_q <= cnt_q + COUNT_W'(BLOCK_SIZE);
						end
						tag_val_q[ib_q[BW-1:0]] <= val_q;
						ib_q <= ib_q + XW'(1);
					end else begin
						ptr_q   <= ib_q * BS_X;
						state_q <= S_INNER_RD;
					end
				end
				S_INNER_RD: begin
					state_q <= S_INNER_CMP;
				end
				S_INNER_CMP: begin
					if (mem_rd == val_q) begin
						cnt_q <= cnt_q + COUNT_W'(1);
					end
					if (ptr_q == blk_last(ib_q)) begin
						tag_vld_q[ib_q[BW-1:0]] <= 1'b1;
						tag_val_q[ib_q[BW-1:0]] <= val_q;
						ib_q    <= ib_q + XW'(1);
						state_q <= S_INNER;
					end else begin
						ptr_q   <= ptr_q + XW'(1);
						state_q <= S_INNER_RD;
					end
				end
				S_DONE: begin
					done    <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

### verif/testbench.sv
module testbench;
	import rcea_pkg::*;

	localparam int unsigned DEPTH  = 1024;
	localparam int unsigned BSIZE  = 32;
	localparam int unsigned NBLK   = DEPTH / BSIZE;
	localparam int unsigned CYCLE_LIMIT = 20000000;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic                 opcode;
	logic [INDEX_W-1:0]   range_low;
	logic [INDEX_W-1:0]   range_high;
	logic signed [VALUE_W-1:0] value;
	logic                 done;
	logic [COUNT_W-1:0]   match_count;
	logic                 bad_range;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [LEN_W-1:0]     cfg_data;

	range_count_equal_then_assign_unit uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.opcode(opcode), .range_low(range_low), .range_high(range_high),
		.value(value), .done(done), .match_count(match_count),
		.bad_range(bad_range), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	// shadow of the table, the block tags and the length register
	logic [VALUE_W-1:0] shadow_entry [DEPTH];
	logic [VALUE_W-1:0] shadow_tag   [NBLK];
	logic               shadow_tagged[NBLK];
	int unsigned        shadow_len;

	result_t     pending_results[$];
	int unsigned fail_count;
	int unsigned cycle_count;
	bit          calm;
	logic [VALUE_W-1:0] value_pool[4];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void spill_block(int unsigned b);
		if (!shadow_tagged[b]) return;
		for (int unsigned i = b * BSIZE; i < (b + 1) * BSIZE; i++)
			shadow_entry[i] = shadow_tag[b];
		shadow_tagged[b] = 1'b0;
	endfunction

	// lo..hi inside one block
	function automatic int unsigned partial_assign(int unsigned lo, int unsigned hi,
			logic [VALUE_W-1:0] v);
		int unsigned b;
		int unsigned n;
		b = lo / BSIZE;
		n = 0;
		if (shadow_tagged[b] && shadow_tag[b] == v) return hi - lo + 1;
		spill_block(b);
		for (int unsigned i = lo; i <= hi; i++) begin
			if (shadow_entry[i] == v) n++;
			else shadow_entry[i] = v;
		end
		return n;
	endfunction

	function automatic result_t count_and_assign(opcode_t op, int unsigned lo,
			int unsigned hi, logic [VALUE_W-1:0] v);
		result_t     r;
		int unsigned len;
		int unsigned cnt;
		int unsigned bl;
		int unsigned bh;
		len = (shadow_len > DEPTH) ? DEPTH : shadow_len;
		cnt = 0;
		r.bad_range = 1'b0;
		if (op == OP_LOAD) begin
			if (lo >= len) r.bad_range = 1'b1;
			else begin
				spill_block(lo / BSIZE);
				shadow_entry[lo] = v;
			end
		end else if (lo > hi || hi >= len) begin
			r.bad_range = 1'b1;
		end else begin
			bl = lo / BSIZE;
			bh = hi / BSIZE;
			if (bl == bh) cnt = partial_assign(lo, hi, v);
			else begin
				cnt = partial_assign(lo, bl * BSIZE + BSIZE - 1, v);
				for (int unsigned b = bl + 1; b < bh; b++) begin
					if (shadow_tagged[b]) begin
						if (shadow_tag[b] == v) cnt += BSIZE;
					end else begin
						for (int unsigned i = b * BSIZE; i < (b + 1) * BSIZE; i++)
							if (shadow_entry[i] == v) cnt++;
					end
					shadow_tag[b] = v;
					shadow_tagged[b] = 1'b1;
				end
				cnt += partial_assign(bh * BSIZE, hi, v);
			end
		end
		r.match_count = cnt[COUNT_W-1:0];
		return r;
	endfunction

	task automatic send_item(opcode_t op, int unsigned lo, int unsigned hi,
			logic [VALUE_W-1:0] v);
		if (!calm && $urandom_range(99) < 14)
			repeat ($urandom_range(1, 6)) @(posedge clk);
		start      <= 1'b1;
		opcode     <= op;
		range_low  <= lo[INDEX_W-1:0];
		range_high <= hi[INDEX_W-1:0];
		value      <= v;
		do @(posedge clk); while (busy);
		pending_results.push_back(count_and_assign(op, lo, hi, v));
		start <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_length(int unsigned len);
		wait (pending_results.size() == 0);
		repeat (130) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= len[LEN_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		shadow_len = len;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [VALUE_W-1:0] pick_value();
		if ($urandom_range(3) == 0) return $urandom;
		return value_pool[$urandom_range(3)];
	endfunction

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** range_count_equal_then_assign_unit: FAILED **");
			$finish;
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result with nothing expected: match_count %0d bad_range %0b",
					match_count, bad_range);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (match_count !== want.match_count) begin
					$error("match_count expected %0d actual %0d",
						want.match_count, match_count);
					fail_count++;
				end
				if (bad_range !== want.bad_range) begin
					$error("bad_range expected %0b actual %0b", want.bad_range, bad_range);
					fail_count++;
				end
			end
		end
	end

	// every entry gets written before any query reads it
	task automatic test_fill();
		for (int unsigned i = 0; i < DEPTH; i++)
			send_item(OP_LOAD, i, $urandom_range(DEPTH - 1), pick_value());
	endtask

	task automatic test_directed();
		send_item(OP_QUERY, 0, DEPTH - 1, value_pool[0]);
		send_item(OP_QUERY, 0, DEPTH - 1, value_pool[0]);
		send_item(OP_QUERY, 5, 4, value_pool[1]);
		send_item(OP_QUERY, DEPTH - 1, 0, value_pool[1]);
		send_item(OP_LOAD, 40, 0, 32'h8000_0000);
		send_item(OP_QUERY, 33, 70, 32'h8000_0000);
		send_item(OP_QUERY, 64, 95, 32'h7fff_ffff);
		send_item(OP_QUERY, 70, 70, 32'h7fff_ffff);
		send_item(OP_QUERY, 100, 100, 32'h0);
		send_item(OP_QUERY, 31, 32, 32'hffff_ffff);
		send_item(OP_QUERY, 0, 1023, 32'hffff_ffff);
		write_length(1000);
		send_item(OP_QUERY, 10, DEPTH - 1, value_pool[2]);
		send_item(OP_QUERY, 10, 999, value_pool[2]);
		send_item(OP_LOAD, 1000, 0, value_pool[3]);
		send_item(OP_LOAD, 999, 0, value_pool[3]);
		write_length(0);
		send_item(OP_LOAD, 0, 0, value_pool[3]);
		send_item(OP_QUERY, 0, 0, value_pool[3]);
		write_length(2047);
		send_item(OP_QUERY, 0, DEPTH - 1, value_pool[1]);
		send_item(OP_LOAD, DEPTH - 1, DEPTH - 1, value_pool[2]);
		write_length(1);
		send_item(OP_QUERY, 0, 0, value_pool[2]);
		send_item(OP_QUERY, 0, 1, value_pool[2]);
		send_item(OP_LOAD, 1, 0, value_pool[2]);
	endtask

	task automatic test_random(int unsigned count);
		int unsigned len;
		int unsigned lo;
		int unsigned hi;
		len = (shadow_len > DEPTH) ? DEPTH : shadow_len;
		for (int unsigned n = 0; n < count; n++) begin
			if (len == 0 || $urandom_range(19) == 0) begin
				lo = $urandom_range(DEPTH - 1);
				hi = $urandom_range(DEPTH - 1);
			end else begin
				lo = $urandom_range(len - 1);
				hi = ($urandom_range(3) == 0) ? $urandom_range(lo, len - 1)
					: $urandom_range(lo, (lo + 70 < len) ? lo + 70 : len - 1);
			end
			if ($urandom_range(3) == 0) send_item(OP_LOAD, lo, hi, pick_value());
			else send_item(OP_QUERY, lo, hi, pick_value());
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		start       = 1'b0;
		opcode      = 1'b0;
		range_low   = '0;
		range_high  = '0;
		value       = '0;
		cfg_valid   = 1'b0;
		cfg_data    = '0;
		fail_count  = 0;
		cycle_count = 0;
		calm        = 1'b0;
		shadow_len  = DEPTH;
		for (int unsigned b = 0; b < NBLK; b++) shadow_tagged[b] = 1'b0;
		value_pool[0] = 32'h8000_0000;
		value_pool[1] = 32'h7fff_ffff;
		value_pool[2] = $urandom;
		value_pool[3] = 32'h0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_fill();
		test_directed();
		write_length(DEPTH);
		test_random(300);
		calm = 1'b1;
		test_random(150);
		calm = 1'b0;
		write_length(200);
		test_random(150);
		write_length(1 + $urandom_range(DEPTH - 2));
		test_random(150);
		write_length(1500);
		test_random(150);

		wait (pending_results.size() == 0);
		repeat (150) @(posedge clk);
		if (pending_results.size() != 0) fail_count++;
		if (fail_count == 0)
			$display("** range_count_equal_then_assign_unit: PASSED **");
		else
			$display("** range_count_equal_then_assign_unit: FAILED **");
		$finish;
	end
endmodule
